// ===== hdl/ppjr_pkg.sv =====
package ppjr_pkg;

  // Widths of the fixed-point datapath
  localparam int CAM_W     = 28;  // camera coordinate, Q.16 after the floor
  localparam int DEN_W     = 27;  // magnitude of a positive depth
  localparam int NUM_W     = 50;  // magnitude of the widest dividend
  localparam int CNT_W     = $clog2(NUM_W);
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);
  localparam int OP_W      = 5;

  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_Z  = 3'd5;

  localparam logic [CFG_W-1:0] ROT_ROW0_RESET = 48'h0000_0000_4000;
  localparam logic [CFG_W-1:0] ROT_ROW1_RESET = 48'h0000_4000_0000;
  localparam logic [CFG_W-1:0] ROT_ROW2_RESET = 48'h4000_0000_0000;

  // Back-end micro-ops, run in this order for a point with good depth
  localparam logic [OP_W-1:0] OP_X    = 5'd0;
  localparam logic [OP_W-1:0] OP_Y    = 5'd1;
  localparam logic [OP_W-1:0] OP_INV  = 5'd2;
  localparam logic [OP_W-1:0] OP_XZ   = 5'd3;
  localparam logic [OP_W-1:0] OP_YZ   = 5'd4;
  localparam logic [OP_W-1:0] OP_XY   = 5'd5;
  localparam logic [OP_W-1:0] OP_XX   = 5'd6;
  localparam logic [OP_W-1:0] OP_YY   = 5'd7;
  localparam logic [OP_W-1:0] OP_R20X = 5'd8;
  localparam logic [OP_W-1:0] OP_P0U  = 5'd9;
  localparam logic [OP_W-1:0] OP_R21X = 5'd10;
  localparam logic [OP_W-1:0] OP_P1U  = 5'd11;
  localparam logic [OP_W-1:0] OP_R20Y = 5'd12;
  localparam logic [OP_W-1:0] OP_P0V  = 5'd13;
  localparam logic [OP_W-1:0] OP_R21Y = 5'd14;
  localparam logic [OP_W-1:0] OP_P1V  = 5'd15;
  localparam logic [OP_W-1:0] OP_XP1U = 5'd16;
  localparam logic [OP_W-1:0] OP_YP0U = 5'd17;
  localparam logic [OP_W-1:0] OP_XP1V = 5'd18;
  localparam logic [OP_W-1:0] OP_YP0V = 5'd19;
  localparam logic [OP_W-1:0] OP_LAST = OP_YP0V;

  localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] S32_MIN = 64'shFFFF_FFFF_8000_0000;
  localparam logic signed [63:0] ONE_Q32 = 64'sh0000_0001_0000_0000;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV_GO,
    BK_DIV_WAIT,
    BK_MUL,
    BK_MUL_WB,
    BK_EMIT_U,
    BK_EMIT_V
  } back_state_t;

  typedef struct packed {
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic signed [23:0] point_z;
    logic               last_point;
  } point_t;

  typedef struct packed {
    logic               row_is_v;
    logic signed [31:0] pose_term0;
    logic signed [31:0] pose_term1;
    logic signed [31:0] pose_term2;
    logic signed [31:0] pose_term3;
    logic signed [31:0] pose_term4;
    logic signed [31:0] pose_term5;
    logic signed [31:0] plane_term0;
    logic signed [31:0] plane_term1;
    logic signed [31:0] plane_term2;
    logic               depth_bad;
    logic               set_done;
  } row_t;

  // One transformed point, handed from the front end to the back end
  typedef struct packed {
    logic signed [CAM_W-1:0] xc;
    logic signed [CAM_W-1:0] yc;
    logic signed [CAM_W-1:0] zc;
    logic signed [23:0]      px;
    logic signed [23:0]      py;
    logic                    last;
    logic                    bad;
  } job_t;

  function automatic logic signed [15:0] rot_col(input logic [CFG_W-1:0] row,
                                                 input logic [1:0] col);
    logic signed [15:0] r;
    unique case (col)
      2'd0:    r = row[15:0];
      2'd1:    r = row[31:16];
      default: r = row[47:32];
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < S32_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic op_is_div(input logic [OP_W-1:0] op);
    return (op == OP_X) || (op == OP_Y) || (op == OP_INV) || (op == OP_XZ) ||
           (op == OP_YZ) || (op == OP_P0U) || (op == OP_P1U) ||
           (op == OP_P0V) || (op == OP_P1V);
  endfunction

endpackage

// ===== hdl/ppjr_front.sv =====
module ppjr_front import ppjr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  point_t             in_data,
  input  logic [CFG_W-1:0]   rot_row0,
  input  logic [CFG_W-1:0]   rot_row1,
  input  logic [CFG_W-1:0]   rot_row2,
  input  logic signed [23:0] trans_x,
  input  logic signed [23:0] trans_y,
  input  logic signed [23:0] trans_z,
  output logic               job_valid,
  input  logic               job_ready,
  output job_t               job
);

  logic [CFG_W-1:0]   rows [0:2];
  logic signed [23:0] coords [0:2];
  logic signed [23:0] trans [0:2];

  logic               s1_valid;
  logic signed [39:0] prod [0:8];
  logic signed [23:0] s1_px;
  logic signed [23:0] s1_py;
  logic               s1_last;
  logic               s1_move;

  logic signed [41:0]      sum [0:2];
  logic signed [CAM_W-1:0] cam [0:2];

  assign rows[0]   = rot_row0;
  assign rows[1]   = rot_row1;
  assign rows[2]   = rot_row2;
  assign coords[0] = in_data.point_x;
  assign coords[1] = in_data.point_y;
  assign coords[2] = in_data.point_z;
  assign trans[0]  = trans_x;
  assign trans[1]  = trans_y;
  assign trans[2]  = trans_z;

  assign s1_move  = s1_valid && (!job_valid || job_ready);
  assign in_ready = !s1_valid || s1_move;

  // Stage 1: nine rotation products
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[3*r+c] <= 40'(rot_col(rows[r], 2'(c))) * 40'(coords[c]);
        end
      end
      s1_px   <= in_data.point_x;
      s1_py   <= in_data.point_y;
      s1_last <= in_data.last_point;
    end
  end

  // Stage 2: add translation, floor to Q.16
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = 42'({{2{prod[3*r][39]}}, prod[3*r]}) +
               42'({{2{prod[3*r+1][39]}}, prod[3*r+1]}) +
               42'({{2{prod[3*r+2][39]}}, prod[3*r+2]}) +
               {{4{trans[r][23]}}, trans[r], 14'b0};
      cam[r] = sum[r][41:14];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      job.xc   <= cam[0];
      job.yc   <= cam[1];
      job.zc   <= cam[2];
      job.px   <= s1_px;
      job.py   <= s1_py;
      job.last <= s1_last;
      job.bad  <= cam[2][CAM_W-1] || (cam[2] == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      job_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        job_valid <= 1'b1;
      end else if (job_ready) begin
        job_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/ppjr_queue.sv =====
module ppjr_queue import ppjr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_data
);

  job_t              mem [0:QDEPTH-1];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/ppjr_div.sv =====
module ppjr_div import ppjr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic [DEN_W-1:0]   den,
  output logic               done,
  output logic signed [31:0] quo
);

  logic             running;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] q;
  logic             neg;

  logic signed [63:0] mag;
  logic [DEN_W:0]     trial;
  logic [DEN_W:0]     diff;
  logic               ge;
  logic signed [63:0] qext;
  logic signed [63:0] sval;

  // Radix-2 restoring divide on magnitudes, truncating toward zero
  always_comb begin
    mag   = num[63] ? -num : num;
    trial = {rem, q[NUM_W-1]};
    diff  = trial - {1'b0, den};
    ge    = (trial >= {1'b0, den});
    qext  = {{(64-NUM_W){1'b0}}, q};
    sval  = neg ? -qext : qext;
    quo   = sat32(sval);
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= num[63];
      q   <= mag[NUM_W-1:0];
      rem <= '0;
    end else if (running) begin
      rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      q   <= {q[NUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/ppjr_back.sv =====
module ppjr_back import ppjr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  output logic             job_ready,
  input  job_t             job,
  input  logic [CFG_W-1:0] rot_row0,
  input  logic [CFG_W-1:0] rot_row1,
  input  logic [CFG_W-1:0] rot_row2,
  output logic             out_valid,
  input  logic             out_ready,
  output row_t             out_data
);

  back_state_t state;
  back_state_t state_next;
  logic [OP_W-1:0] op;

  logic signed [31:0] x_val, y_val, inv, xz, yz;
  logic signed [31:0] t_xy, t_nxy, t_nxx, t_yy;
  logic signed [31:0] p0u, p1u, p2u, p0v, p1v, p2v;
  logic signed [63:0] prod;
  logic signed [63:0] hold;

  logic signed [15:0] r00, r01, r10, r11, r20, r21;
  logic signed [63:0] div_num;
  logic               div_start;
  logic               div_done;
  logic signed [31:0] div_quo;
  logic signed [31:0] ma;
  logic signed [31:0] mb;
  logic signed [63:0] nprod;
  logic               load;
  logic               advance;
  back_state_t        adv_state;
  logic [OP_W-1:0]    op_inc;
  row_t               u_row;
  row_t               v_row;
  logic signed [31:0] neg_inv;
  logic signed [31:0] neg_x;

  assign r00 = rot_col(rot_row0, 2'd0);
  assign r01 = rot_col(rot_row0, 2'd1);
  assign r10 = rot_col(rot_row1, 2'd0);
  assign r11 = rot_col(rot_row1, 2'd1);
  assign r20 = rot_col(rot_row2, 2'd0);
  assign r21 = rot_col(rot_row2, 2'd1);

  ppjr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (job.zc[DEN_W-1:0]),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Dividend and multiplier operands for the current op
  always_comb begin
    div_num = '0;
    ma      = '0;
    mb      = '0;
    unique case (op)
      OP_X:    div_num = {{20{job.xc[CAM_W-1]}}, job.xc, 16'b0};
      OP_Y:    div_num = {{20{job.yc[CAM_W-1]}}, job.yc, 16'b0};
      OP_INV:  div_num = ONE_Q32;
      OP_XZ:   div_num = {{16{x_val[31]}}, x_val, 16'b0};
      OP_YZ:   div_num = {{16{y_val[31]}}, y_val, 16'b0};
      OP_P0U:  div_num = (prod - {{32{r00[15]}}, r00, 16'b0}) <<< 2;
      OP_P1U:  div_num = (prod - {{32{r01[15]}}, r01, 16'b0}) <<< 2;
      OP_P0V:  div_num = (prod - {{32{r10[15]}}, r10, 16'b0}) <<< 2;
      OP_P1V:  div_num = (prod - {{32{r11[15]}}, r11, 16'b0}) <<< 2;
      OP_XY:   begin ma = x_val; mb = y_val; end
      OP_XX:   begin ma = x_val; mb = x_val; end
      OP_YY:   begin ma = y_val; mb = y_val; end
      OP_R20X: begin ma = {{16{r20[15]}}, r20}; mb = x_val; end
      OP_R21X: begin ma = {{16{r21[15]}}, r21}; mb = x_val; end
      OP_R20Y: begin ma = {{16{r20[15]}}, r20}; mb = y_val; end
      OP_R21Y: begin ma = {{16{r21[15]}}, r21}; mb = y_val; end
      OP_XP1U: begin ma = {{8{job.px[23]}}, job.px}; mb = p1u; end
      OP_YP0U: begin ma = {{8{job.py[23]}}, job.py}; mb = p0u; end
      OP_XP1V: begin ma = {{8{job.px[23]}}, job.px}; mb = p1v; end
      OP_YP0V: begin ma = {{8{job.py[23]}}, job.py}; mb = p0v; end
      default: ;
    endcase
  end

  assign nprod   = -prod;
  assign op_inc  = op + 1'b1;
  assign advance = ((state == BK_DIV_WAIT) && div_done) || (state == BK_MUL_WB);

  always_comb begin
    if (op == OP_LAST) begin
      adv_state = BK_EMIT_U;
    end else if (op_is_div(op_inc)) begin
      adv_state = BK_DIV_GO;
    end else begin
      adv_state = BK_MUL;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (job_valid) begin
          state_next = job.bad ? BK_EMIT_U : BK_DIV_GO;
        end
      end
      BK_DIV_GO:   state_next = BK_DIV_WAIT;
      BK_DIV_WAIT: if (div_done) state_next = adv_state;
      BK_MUL:      state_next = BK_MUL_WB;
      BK_MUL_WB:   state_next = adv_state;
      BK_EMIT_U:   if (load) state_next = BK_EMIT_V;
      BK_EMIT_V:   if (load) state_next = BK_IDLE;
      default:     state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    div_start = (state == BK_DIV_GO);
    load      = ((state == BK_EMIT_U) || (state == BK_EMIT_V)) &&
                (!out_valid || out_ready);
    job_ready = (state == BK_EMIT_V) && load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      op    <= '0;
    end else begin
      state <= state_next;
      if (state == BK_IDLE) begin
        op <= OP_X;
      end else if (advance) begin
        op <= op_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_MUL) begin
      prod <= 64'(ma) * 64'(mb);
    end
    if ((state == BK_DIV_WAIT) && div_done) begin
      unique case (op)
        OP_X:    x_val <= div_quo;
        OP_Y:    y_val <= div_quo;
        OP_INV:  inv   <= div_quo;
        OP_XZ:   xz    <= div_quo;
        OP_YZ:   yz    <= div_quo;
        OP_P0U:  p0u   <= div_quo;
        OP_P1U:  p1u   <= div_quo;
        OP_P0V:  p0v   <= div_quo;
        OP_P1V:  p1v   <= div_quo;
        default: ;
      endcase
    end
    if (state == BK_MUL_WB) begin
      unique case (op)
        OP_XY: begin
          t_xy  <= sat32(prod >>> 16);
          t_nxy <= sat32(nprod >>> 16);
        end
        OP_XX:   t_nxx <= sat32((nprod - ONE_Q32) >>> 16);
        OP_YY:   t_yy  <= sat32((prod + ONE_Q32) >>> 16);
        OP_XP1U: hold  <= prod;
        OP_YP0U: p2u   <= sat32((hold - prod) >>> 16);
        OP_XP1V: hold  <= prod;
        OP_YP0V: p2v   <= sat32((hold - prod) >>> 16);
        default: ;
      endcase
    end
  end

  // Build both rows; a bad depth zeroes every term
  always_comb begin
    neg_inv = -inv;
    neg_x   = (x_val == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -x_val;

    u_row             = '0;
    u_row.row_is_v    = 1'b0;
    u_row.depth_bad   = job.bad;
    u_row.set_done    = 1'b0;
    v_row             = '0;
    v_row.row_is_v    = 1'b1;
    v_row.depth_bad   = job.bad;
    v_row.set_done    = job.last;
    if (!job.bad) begin
      u_row.pose_term0  = neg_inv;
      u_row.pose_term2  = xz;
      u_row.pose_term3  = t_xy;
      u_row.pose_term4  = t_nxx;
      u_row.pose_term5  = y_val;
      u_row.plane_term0 = p0u;
      u_row.plane_term1 = p1u;
      u_row.plane_term2 = p2u;
      v_row.pose_term1  = neg_inv;
      v_row.pose_term2  = yz;
      v_row.pose_term3  = t_yy;
      v_row.pose_term4  = t_nxy;
      v_row.pose_term5  = neg_x;
      v_row.plane_term0 = p0v;
      v_row.plane_term1 = p1v;
      v_row.plane_term2 = p2v;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= (state == BK_EMIT_V) ? v_row : u_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== hdl/point_pose_jacobian_rows.sv =====
// Image-point interaction matrix rows for a configured rigid pose.
//
// Input channel (in_valid/in_ready/in_data): one object point per item.
// Output channel (out_valid/out_ready/out_data): two rows per point, the
// u row first and then the v row, which carries set_done for the last point.
// Config port (cfg_we/cfg_idx/cfg_data): rotation rows and translation; write
// only while no point is in flight. Unused indexes are ignored.
//
// A point with positive depth passes the two transform stages, then nine
// divisions and eleven multiplies on the single shared radix-2 divider
// and multiplier before its u row. A point with bad depth skips the
// divisions and multiplies and goes straight to its rows. The back end
// finishes one point before it takes the next one; a two-entry queue
// lets the transform front end take the next points while the back end
// works.
// Reset: registers return to the identity pose, queue and rows are dropped.
// A stalled receiver holds the current row; the back end waits, the queue
// fills, and then in_ready falls.
module point_pose_jacobian_rows import ppjr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  point_t               in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output row_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [CFG_W-1:0]   rot_row0;
  logic [CFG_W-1:0]   rot_row1;
  logic [CFG_W-1:0]   rot_row2;
  logic signed [23:0] trans_x;
  logic signed [23:0] trans_y;
  logic signed [23:0] trans_z;

  logic job_valid;
  logic job_ready;
  job_t job;
  logic head_valid;
  logic head_ready;
  job_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_row0 <= ROT_ROW0_RESET;
      rot_row1 <= ROT_ROW1_RESET;
      rot_row2 <= ROT_ROW2_RESET;
      trans_x  <= '0;
      trans_y  <= '0;
      trans_z  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ROT_ROW0: rot_row0 <= cfg_data;
        REG_ROT_ROW1: rot_row1 <= cfg_data;
        REG_ROT_ROW2: rot_row2 <= cfg_data;
        REG_TRANS_X:  trans_x  <= cfg_data[23:0];
        REG_TRANS_Y:  trans_y  <= cfg_data[23:0];
        REG_TRANS_Z:  trans_z  <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  ppjr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .rot_row0  (rot_row0),
    .rot_row1  (rot_row1),
    .rot_row2  (rot_row2),
    .trans_x   (trans_x),
    .trans_y   (trans_y),
    .trans_z   (trans_z),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  ppjr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (job_valid),
    .push_ready (job_ready),
    .push_data  (job),
    .pop_valid  (head_valid),
    .pop_ready  (head_ready),
    .pop_data   (head)
  );

  ppjr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (head_valid),
    .job_ready (head_ready),
    .job       (head),
    .rot_row0  (rot_row0),
    .rot_row1  (rot_row1),
    .rot_row2  (rot_row2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== hdl/ppjr_check.sv =====
module ppjr_check import ppjr_pkg::*; (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input row_t out_data
);

  logic expect_v;

  // Track which row of the pair comes next
  always_ff @(posedge clk) begin
    if (rst) begin
      expect_v <= 1'b0;
    end else if (out_valid && out_ready) begin
      expect_v <= !expect_v;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("row changed while stalled");

  a_row_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.row_is_v == expect_v)
    else $error("u and v rows out of order");

  a_done_on_v: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.set_done |-> out_data.row_is_v)
    else $error("set_done on a u row");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.depth_bad |->
      out_data.pose_term0 == 0 && out_data.pose_term1 == 0 &&
      out_data.pose_term2 == 0 && out_data.pose_term3 == 0 &&
      out_data.pose_term4 == 0 && out_data.pose_term5 == 0 &&
      out_data.plane_term0 == 0 && out_data.plane_term1 == 0 &&
      out_data.plane_term2 == 0)
    else $error("nonzero term with bad depth");

  a_v_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.row_is_v |=> out_valid)
    else $error("v row did not follow its u row");

endmodule

bind point_pose_jacobian_rows ppjr_check u_check (.*);

// ===== verif/point_pose_jacobian_rows_tb.sv =====
module point_pose_jacobian_rows_tb;
  import ppjr_pkg::*;

  typedef struct {
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [23:0] pz;
    logic               last;
    logic               known_bad;
  } dir_row_t;

  localparam int PHASES      = 8;
  localparam int PER_PHASE   = 70;
  localparam int IDLE_NONE   = 0;
  localparam int IDLE_SEND   = 1;
  localparam int IDLE_RECV   = 2;
  localparam int IDLE_BOTH   = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE7 = 3'd7;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  point_t               in_data;
  logic                 out_valid;
  logic                 out_ready;
  row_t                 out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  // Shadow of the pose registers
  logic [47:0] pose_rot [3];
  logic [23:0] pose_trans [3];

  row_t rows_pending [$];
  int   fail_cnt;
  int   rows_seen;
  int   points_sent;
  int   bad_points;
  int   idle_mode;
  bit   quiet;

  dir_row_t dir_tab [] = '{
    '{24'sh000000, 24'sh000000, 24'sh010000, 1'b0, 1'b0},
    '{24'sh000000, 24'sh000000, 24'sh000000, 1'b0, 1'b1},
    '{24'sh000000, 24'sh000000, -24'sh010000, 1'b1, 1'b1},
    '{24'sh000000, 24'sh000000, 24'sh7FFFFF, 1'b0, 1'b0},
    '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 1'b0, 1'b1},
    '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh000001, 1'b0, 1'b0},
    '{24'sh800000, 24'sh800000, 24'sh000001, 1'b1, 1'b0},
    '{24'sh7FFFFF, 24'sh800000, 24'sh010000, 1'b0, 1'b0},
    '{24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 1'b0, 1'b0},
    '{24'sh010000, -24'sh008000, 24'sh020000, 1'b1, 1'b0},
    '{24'sh123456, 24'sh654321, 24'sh0ABCDE, 1'b0, 1'b0},
    '{24'shAAAAAA, 24'sh555555, 24'sh555555, 1'b0, 1'b0},
    '{24'sh555555, 24'shAAAAAA, 24'sh2AAAAA, 1'b1, 1'b0},
    '{24'sh000001, 24'shFFFFFF, 24'sh000002, 1'b0, 1'b0}
  };

  point_pose_jacobian_rows dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint rot_at(int r, int c);
    logic signed [15:0] e;
    e = pose_rot[r][16*c +: 16];
    return longint'(e);
  endfunction

  function automatic longint camera_coord(int r, longint px, longint py, longint pz);
    longint acc;
    acc = rot_at(r, 0) * px + rot_at(r, 1) * py + rot_at(r, 2) * pz
        + longint'($signed(pose_trans[r])) * 16384;
    return acc >>> 14;
  endfunction

  // Work out both rows of one point
  task automatic jacobian_rows(input point_t p, output row_t u, output row_t v);
    longint px, py, pz, xc, yc, zc, x, y, inv, one, r20, r21, p0, p1;
    px = longint'(p.point_x);
    py = longint'(p.point_y);
    pz = longint'(p.point_z);
    xc = camera_coord(0, px, py, pz);
    yc = camera_coord(1, px, py, pz);
    zc = camera_coord(2, px, py, pz);
    u = '0;
    v = '0;
    v.row_is_v = 1'b1;
    u.depth_bad = (zc <= 0);
    v.depth_bad = (zc <= 0);
    v.set_done = p.last_point;
    if (zc > 0) begin
      one = 64'sd1 <<< 32;
      x = clamp32((xc * 65536) / zc);
      y = clamp32((yc * 65536) / zc);
      inv = clamp32(one / zc);
      u.pose_term0 = 32'(clamp32(-inv));
      u.pose_term2 = 32'(clamp32((x * 65536) / zc));
      u.pose_term3 = 32'(clamp32((x * y) >>> 16));
      u.pose_term4 = 32'(clamp32((-(x * x) - one) >>> 16));
      u.pose_term5 = 32'(y);
      v.pose_term1 = 32'(clamp32(-inv));
      v.pose_term2 = 32'(clamp32((y * 65536) / zc));
      v.pose_term3 = 32'(clamp32((y * y + one) >>> 16));
      v.pose_term4 = 32'(clamp32((-(x * y)) >>> 16));
      v.pose_term5 = 32'(clamp32(-x));
      r20 = rot_at(2, 0);
      r21 = rot_at(2, 1);
      p0 = clamp32(((r20 * x - rot_at(0, 0) * 65536) * 4) / zc);
      p1 = clamp32(((r21 * x - rot_at(0, 1) * 65536) * 4) / zc);
      u.plane_term0 = 32'(p0);
      u.plane_term1 = 32'(p1);
      u.plane_term2 = 32'(clamp32((px * p1 - py * p0) >>> 16));
      p0 = clamp32(((r20 * y - rot_at(1, 0) * 65536) * 4) / zc);
      p1 = clamp32(((r21 * y - rot_at(1, 1) * 65536) * 4) / zc);
      v.plane_term0 = 32'(p0);
      v.plane_term1 = 32'(p1);
      v.plane_term2 = 32'(clamp32((px * p1 - py * p0) >>> 16));
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("row %0d: %s got %h want %h", rows_seen, what, got, want);
    fail_cnt++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_ROT_ROW0: pose_rot[0] = val;
      REG_ROT_ROW1: pose_rot[1] = val;
      REG_ROT_ROW2: pose_rot[2] = val;
      REG_TRANS_X:  pose_trans[0] = val[23:0];
      REG_TRANS_Y:  pose_trans[1] = val[23:0];
      REG_TRANS_Z:  pose_trans[2] = val[23:0];
      default: ;
    endcase
  endtask

  task automatic send_point(input point_t p, input logic known_bad);
    row_t u, v;
    int gap;
    in_data <= p;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    jacobian_rows(p, u, v);
    if (known_bad) begin
      u = '0;
      u.depth_bad = 1'b1;
      v = u;
      v.row_is_v = 1'b1;
      v.set_done = p.last_point;
    end
    rows_pending.push_back(u);
    rows_pending.push_back(v);
    points_sent++;
    if (u.depth_bad) bad_points++;
    if (!quiet && (idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH)) begin
      gap = (idle_mode == IDLE_SEND) ? 70 : 29;
      if ($urandom_range(99) < gap) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (rows_pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic point_t random_point();
    point_t p;
    p.point_x = 24'($urandom);
    p.point_y = 24'($urandom);
    p.point_z = 24'($urandom);
    p.last_point = ($urandom_range(7) == 0);
    // mostly moderate points in front of the camera
    if ($urandom_range(9) < 7) begin
      p.point_x = $signed(24'($urandom_range(0, 24'h0FFFFF))) - 24'sh080000;
      p.point_y = $signed(24'($urandom_range(0, 24'h0FFFFF))) - 24'sh080000;
      p.point_z = 24'($urandom_range(24'h000100, 24'h3FFFFF));
    end
    return p;
  endfunction

  function automatic logic [47:0] random_rot_row();
    logic [47:0] r;
    for (int c = 0; c < 3; c++) begin
      r[16*c +: 16] = 16'($urandom_range(0, 16'h8000)) - 16'h4000;
    end
    return r;
  endfunction

  task automatic configure(input int phase);
    logic [47:0] rr [3];
    logic [23:0] tt [3];
    case (phase)
      1: begin
        rr[0] = ROT_ROW0_RESET;
        rr[1] = ROT_ROW1_RESET;
        rr[2] = 48'h0001_0000_0000;
        tt = '{24'h0, 24'h0, 24'h0};
      end
      2: begin
        rr = '{48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF};
        tt = '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF};
      end
      3: begin
        rr = '{48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000};
        tt = '{24'h800000, 24'h800000, 24'h800000};
      end
      default: begin
        for (int i = 0; i < 3; i++) begin
          rr[i] = random_rot_row();
          tt[i] = $signed(24'($urandom_range(0, 24'h3FFFFF))) - 24'sh200000;
        end
        rr[2][47:32] = 16'($urandom_range(16'h1000, 16'h4000));
      end
    endcase
    write_reg(REG_ROT_ROW0, rr[0]);
    write_reg(REG_ROT_ROW1, rr[1]);
    write_reg(REG_ROT_ROW2, rr[2]);
    // upper bits on the translation writes must be dropped
    write_reg(REG_TRANS_X, {24'($urandom), tt[0]});
    write_reg(REG_TRANS_Y, {24'($urandom), tt[1]});
    write_reg(REG_TRANS_Z, {24'($urandom), tt[2]});
    write_reg(REG_SPARE6, 48'({$urandom, $urandom}));
    write_reg(REG_SPARE7, 48'({$urandom, $urandom}));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: check every accepted row, then pick the next ready level
  always @(posedge clk) begin
    row_t want;
    if (!rst && out_valid && out_ready) begin
      if (rows_pending.size() == 0) begin
        report_mismatch("unexpected row", 64'(out_data.row_is_v), 64'd0);
      end else begin
        want = rows_pending.pop_front();
        if (out_data.row_is_v !== want.row_is_v)
          report_mismatch("row_is_v", 64'(out_data.row_is_v), 64'(want.row_is_v));
        if (out_data.pose_term0 !== want.pose_term0)
          report_mismatch("pose_term0", 64'(out_data.pose_term0), 64'(want.pose_term0));
        if (out_data.pose_term1 !== want.pose_term1)
          report_mismatch("pose_term1", 64'(out_data.pose_term1), 64'(want.pose_term1));
        if (out_data.pose_term2 !== want.pose_term2)
          report_mismatch("pose_term2", 64'(out_data.pose_term2), 64'(want.pose_term2));
        if (out_data.pose_term3 !== want.pose_term3)
          report_mismatch("pose_term3", 64'(out_data.pose_term3), 64'(want.pose_term3));
        if (out_data.pose_term4 !== want.pose_term4)
          report_mismatch("pose_term4", 64'(out_data.pose_term4), 64'(want.pose_term4));
        if (out_data.pose_term5 !== want.pose_term5)
          report_mismatch("pose_term5", 64'(out_data.pose_term5), 64'(want.pose_term5));
        if (out_data.plane_term0 !== want.plane_term0)
          report_mismatch("plane_term0", 64'(out_data.plane_term0), 64'(want.plane_term0));
        if (out_data.plane_term1 !== want.plane_term1)
          report_mismatch("plane_term1", 64'(out_data.plane_term1), 64'(want.plane_term1));
        if (out_data.plane_term2 !== want.plane_term2)
          report_mismatch("plane_term2", 64'(out_data.plane_term2), 64'(want.plane_term2));
        if (out_data.depth_bad !== want.depth_bad)
          report_mismatch("depth_bad", 64'(out_data.depth_bad), 64'(want.depth_bad));
        if (out_data.set_done !== want.set_done)
          report_mismatch("set_done", 64'(out_data.set_done), 64'(want.set_done));
      end
      rows_seen++;
    end
    if (!quiet && idle_mode == IDLE_RECV)
      out_ready <= ($urandom_range(99) >= 70);
    else if (!quiet && idle_mode == IDLE_BOTH)
      out_ready <= ($urandom_range(99) >= 29);
    else
      out_ready <= 1'b1;
  end

  initial begin
    #(4 * 4000000);
    $display("timeout with %0d rows outstanding", rows_pending.size());
    $display("point_pose_jacobian_rows regression: fail");
    $finish;
  end

  initial begin
    point_t p;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    fail_cnt = 0;
    rows_seen = 0;
    points_sent = 0;
    bad_points = 0;
    idle_mode = IDLE_NONE;
    quiet = 1'b0;
    pose_rot = '{ROT_ROW0_RESET, ROT_ROW1_RESET, ROT_ROW2_RESET};
    pose_trans = '{24'h0, 24'h0, 24'h0};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed points against the reset pose
    foreach (dir_tab[i]) begin
      p.point_x = dir_tab[i].px;
      p.point_y = dir_tab[i].py;
      p.point_z = dir_tab[i].pz;
      p.last_point = dir_tab[i].last;
      send_point(p, dir_tab[i].known_bad);
    end
    drain();

    for (int ph = 1; ph < PHASES; ph++) begin
      configure(ph);
      idle_mode = ph % 4;
      // a depth of one LSB in the object frame, floors to zero for tiny r22
      p = '0;
      p.point_z = 24'sh000001;
      send_point(p, 1'b0);
      for (int n = 0; n < PER_PHASE; n++) begin
        quiet = (n % 20) < 5;
        if (ph == 2 && n == 30) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (rows_pending.size() != 0) @(posedge clk);
        end
        send_point(random_point(), 1'b0);
      end
      quiet = 1'b0;
      drain();
    end

    $display("%0d points (%0d with bad depth) and %0d rows checked over %0d poses",
             points_sent, bad_points, rows_seen, PHASES);
    if (fail_cnt == 0) begin
      $display("point_pose_jacobian_rows regression: pass");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("point_pose_jacobian_rows regression: fail");
    end
    $finish;
  end

endmodule
